// ===== sv/skts_pkg.sv =====
`timescale 1ns / 1ps

package skts_pkg;

    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int VAL_W  = 32;
    localparam int CFG_W  = 13;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 104;

    typedef enum logic [2:0] {
        CMD_INV_DIAG    = 3'd0,
        CMD_LOWER_WIDTH = 3'd1,
        CMD_UPPER_WIDTH = 3'd2,
        CMD_LOWER_ENTRY = 3'd3,
        CMD_UPPER_ENTRY = 3'd4,
        CMD_RHS_ROW     = 3'd5,
        CMD_SOLVE       = 3'd6,
        CMD_READ        = 3'd7
    } cmd_t;

    typedef enum logic {
        RES_SOLVE_DONE = 1'b0,
        RES_ROW_DATA   = 1'b1
    } res_kind_t;

    typedef enum logic {
        REG_ROWS_IN_USE       = 1'b0,
        REG_UPPER_ENTRY_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        PASS_FWD = 1'b0,
        PASS_BWD = 1'b1
    } pass_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_DATA,
        ST_ROW_RD,
        ST_ROW_LAT,
        ST_SC_MUL,
        ST_SC_WR,
        ST_EL_CHK,
        ST_EL_LAT,
        ST_EL_MUL,
        ST_EL_WR,
        ST_ROW_END,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/skyline_triangular_solve_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------------
// s_       | s_tvalid / s_tready | tuser: command; tdata: row, entry, width, x,y,z
// m_       | m_tvalid / m_tready | tuser: result_kind; tdata: row_out, x, y, z
// cfg_     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// A read goes via ST_READ_DATA to the result registers. A solve runs on one shared
// 32x32 multiplier: per pass and row it scales by the inverse diagonal, then
// eliminates each band entry whose target row is in range. s_tready is low during
// a solve or read, and while a result waits with m_tready low. Reset (aresetn,
// synchronous) clears control only; stores hold nothing until loaded. MAX_ROWS
// and MAX_ENTRIES must be powers of two (unchecked) so row and entry indexes wrap.
module skyline_triangular_solve_unit
    import skts_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] row, [19:8] entry_index, [27:20] band_width,
    // [59:28] value_x, [91:60] value_y, [123:92] value_z
    input  logic [S_DATA_W-1:0] s_tdata,
    // [2:0] command
    input  logic [2:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] row_out, [39:8] sol_x, [71:40] sol_y, [103:72] sol_z
    output logic [M_DATA_W-1:0] m_tdata,
    // [0] result_kind
    output logic [0:0]          m_tuser,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ENT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = ROW_W + 1;
    localparam int TW    = ROW_W + 10;

    // input fields
    logic [7:0]              in_row;
    logic [11:0]             in_entry;
    logic [7:0]              in_bw;
    logic signed [VAL_W-1:0] in_x, in_y, in_z;
    cmd_t                    in_cmd;
    logic                    s_fire;

    assign in_row   = s_tdata[7:0];
    assign in_entry = s_tdata[19:8];
    assign in_bw    = s_tdata[27:20];
    assign in_x     = s_tdata[59:28];
    assign in_y     = s_tdata[91:60];
    assign in_z     = s_tdata[123:92];
    assign in_cmd   = cmd_t'(s_tuser);
    assign s_fire   = s_tvalid && s_tready;

    logic [ROW_W-1:0] in_row_idx;
    logic [ENT_W-1:0] in_ent_idx;
    assign in_row_idx = ROW_W'(in_row);
    assign in_ent_idx = ENT_W'(in_entry);

    // configuration
    logic [8:0]       rows_in_use_reg;
    logic [CFG_W-1:0] upper_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg <= 9'd1;
            upper_count_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_ROWS_IN_USE:       rows_in_use_reg <= cfg_wdata[8:0];
                REG_UPPER_ENTRY_COUNT: upper_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer state
    state_t                  state_reg, state_next;
    pass_t                   pass_reg;
    logic [ROW_W-1:0]        i_reg;
    logic [7:0]              j_reg;
    logic [1:0]              comp_reg;
    logic [ENT_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        n_reg;
    logic signed [VAL_W-1:0] d_reg, e_reg;
    logic [7:0]              w_reg;
    logic signed [VAL_W-1:0] src_reg [3];
    logic signed [VAL_W-1:0] tgt_reg [3];
    logic signed [63:0]      prod_reg;
    logic                    m_valid_reg;
    res_kind_t               m_kind_reg;
    logic [7:0]              m_row_reg;
    logic signed [VAL_W-1:0] m_x_reg, m_y_reg, m_z_reg;
    logic [7:0]              rd_row_reg;

    // memories
    logic signed [VAL_W-1:0] inv_diag_mem [MAX_ROWS];
    logic [7:0]              lower_w_mem  [MAX_ROWS];
    logic [7:0]              upper_w_mem  [MAX_ROWS];
    logic signed [VAL_W-1:0] lower_e_mem  [MAX_ENTRIES];
    logic signed [VAL_W-1:0] upper_e_mem  [MAX_ENTRIES];
    logic signed [VAL_W-1:0] vec_x_mem    [MAX_ROWS];
    logic signed [VAL_W-1:0] vec_y_mem    [MAX_ROWS];
    logic signed [VAL_W-1:0] vec_z_mem    [MAX_ROWS];

    logic signed [VAL_W-1:0] diag_rd, lower_e_rd, upper_e_rd, vx_rd, vy_rd, vz_rd;
    logic [7:0]              lower_w_rd, upper_w_rd;

    // band target and entry address
    logic [TW-1:0]    t_fwd;
    logic             t_ok;
    logic [ROW_W-1:0] t_idx;
    logic [ENT_W-1:0] e_addr;
    logic             last_row;

    assign t_fwd = TW'(i_reg) + TW'(j_reg) + TW'(1);

    always_comb begin
        if (pass_reg == PASS_FWD) begin
            t_ok   = t_fwd < TW'(n_reg);
            t_idx  = ROW_W'(t_fwd);
            e_addr = pos_reg + ENT_W'(j_reg);
        end else begin
            t_ok   = (TW'(j_reg) + TW'(1)) <= TW'(i_reg);
            t_idx  = i_reg - ROW_W'(j_reg) - ROW_W'(1);
            e_addr = pos_reg - ENT_W'(j_reg);
        end
    end

    assign last_row = (pass_reg == PASS_FWD) ? ((CNT_W'(i_reg) + CNT_W'(1)) == n_reg)
                                             : (i_reg == '0);

    // arithmetic
    function automatic logic signed [VAL_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[VAL_W-1:0];
        return r;
    endfunction

    logic signed [VAL_W-1:0] mul_a, mul_b, q_val, d_val;
    logic signed [63:0]      diff;

    assign mul_a = src_reg[comp_reg];
    assign mul_b = (state_reg == ST_SC_MUL) ? d_reg : e_reg;
    assign q_val = sat64(prod_reg >>> FRAC_BITS);
    assign diff  = 64'(tgt_reg[comp_reg]) - 64'(q_val);
    assign d_val = sat64(diff);

    // output control
    logic [ROW_W-1:0]        vec_raddr, vec_waddr;
    logic signed [VAL_W-1:0] vec_wx, vec_wy, vec_wz;
    logic [2:0]              vec_we;
    logic signed [VAL_W-1:0] wr_val;

    always_comb begin
        s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
        vec_raddr = i_reg;
        vec_waddr = i_reg;
        vec_we    = 3'b000;
        wr_val    = q_val;
        vec_wx    = wr_val;
        vec_wy    = wr_val;
        vec_wz    = wr_val;
        case (state_reg)
            ST_IDLE: begin
                vec_raddr = in_row_idx;
                vec_waddr = in_row_idx;
                vec_wx    = in_x;
                vec_wy    = in_y;
                vec_wz    = in_z;
                if (s_fire && in_cmd == CMD_RHS_ROW) vec_we = 3'b111;
            end
            ST_EL_CHK: vec_raddr = t_idx;
            ST_SC_WR: begin
                vec_we = 3'b001 << comp_reg;
            end
            ST_EL_WR: begin
                vec_waddr = t_idx;
                vec_wx    = d_val;
                vec_wy    = d_val;
                vec_wz    = d_val;
                vec_we    = 3'b001 << comp_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire && in_cmd == CMD_INV_DIAG) inv_diag_mem[in_row_idx] <= in_x;
        diag_rd <= inv_diag_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && in_cmd == CMD_LOWER_WIDTH) lower_w_mem[in_row_idx] <= in_bw;
        lower_w_rd <= lower_w_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && in_cmd == CMD_UPPER_WIDTH) upper_w_mem[in_row_idx] <= in_bw;
        upper_w_rd <= upper_w_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && in_cmd == CMD_LOWER_ENTRY) lower_e_mem[in_ent_idx] <= in_x;
        lower_e_rd <= lower_e_mem[e_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && in_cmd == CMD_UPPER_ENTRY) upper_e_mem[in_ent_idx] <= in_x;
        upper_e_rd <= upper_e_mem[e_addr];
    end

    always_ff @(posedge aclk) begin
        if (vec_we[0]) vec_x_mem[vec_waddr] <= vec_wx;
        vx_rd <= vec_x_mem[vec_raddr];
    end

    always_ff @(posedge aclk) begin
        if (vec_we[1]) vec_y_mem[vec_waddr] <= vec_wy;
        vy_rd <= vec_y_mem[vec_raddr];
    end

    always_ff @(posedge aclk) begin
        if (vec_we[2]) vec_z_mem[vec_waddr] <= vec_wz;
        vz_rd <= vec_z_mem[vec_raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_cmd == CMD_READ) state_next = ST_READ_DATA;
                else if (s_fire && in_cmd == CMD_SOLVE) begin
                    state_next = (rows_in_use_reg == '0) ? ST_FINISH : ST_ROW_RD;
                end
            end
            ST_READ_DATA: state_next = ST_IDLE;
            ST_ROW_RD:    state_next = ST_ROW_LAT;
            ST_ROW_LAT:   state_next = ST_SC_MUL;
            ST_SC_MUL:    state_next = ST_SC_WR;
            ST_SC_WR:     state_next = (comp_reg == 2'd2) ? ST_EL_CHK : ST_SC_MUL;
            ST_EL_CHK:    state_next = (j_reg == w_reg || !t_ok) ? ST_ROW_END : ST_EL_LAT;
            ST_EL_LAT:    state_next = ST_EL_MUL;
            ST_EL_MUL:    state_next = ST_EL_WR;
            ST_EL_WR:     state_next = (comp_reg == 2'd2) ? ST_EL_CHK : ST_EL_MUL;
            ST_ROW_END: begin
                state_next = (last_row && pass_reg == PASS_BWD) ? ST_FINISH : ST_ROW_RD;
            end
            ST_FINISH:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                rd_row_reg <= in_row;
                i_reg      <= '0;
                pass_reg   <= PASS_FWD;
                pos_reg    <= '0;
                if (32'(rows_in_use_reg) > MAX_ROWS) n_reg <= CNT_W'(MAX_ROWS);
                else n_reg <= CNT_W'(rows_in_use_reg);
            end
            ST_ROW_LAT: begin
                d_reg      <= diag_rd;
                w_reg      <= (pass_reg == PASS_FWD) ? lower_w_rd : upper_w_rd;
                src_reg[0] <= vx_rd;
                src_reg[1] <= vy_rd;
                src_reg[2] <= vz_rd;
                comp_reg   <= 2'd0;
                j_reg      <= '0;
            end
            ST_SC_MUL, ST_EL_MUL: prod_reg <= mul_a * mul_b;
            ST_SC_WR: begin
                src_reg[comp_reg] <= q_val;
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            ST_EL_LAT: begin
                e_reg      <= (pass_reg == PASS_FWD) ? lower_e_rd : upper_e_rd;
                tgt_reg[0] <= vx_rd;
                tgt_reg[1] <= vy_rd;
                tgt_reg[2] <= vz_rd;
                comp_reg   <= 2'd0;
            end
            ST_EL_WR: begin
                if (comp_reg == 2'd2) begin
                    comp_reg <= 2'd0;
                    j_reg    <= j_reg + 8'd1;
                end else begin
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            ST_ROW_END: begin
                if (pass_reg == PASS_FWD) begin
                    if (last_row) begin
                        // turn around: backward pass from the last row and entry
                        pass_reg <= PASS_BWD;
                        pos_reg  <= ENT_W'(32'(upper_count_reg) - 32'd1);
                    end else begin
                        pos_reg <= pos_reg + ENT_W'(w_reg);
                        i_reg   <= i_reg + ROW_W'(1);
                    end
                end else begin
                    pos_reg <= pos_reg - ENT_W'(w_reg);
                    i_reg   <= i_reg - ROW_W'(1);
                end
            end
            default: ;
        endcase
    end

    // result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_READ_DATA || state_reg == ST_FINISH) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ_DATA) begin
            m_kind_reg <= RES_ROW_DATA;
            m_row_reg  <= rd_row_reg;
            m_x_reg    <= vx_rd;
            m_y_reg    <= vy_rd;
            m_z_reg    <= vz_rd;
        end else if (state_reg == ST_FINISH) begin
            m_kind_reg <= RES_SOLVE_DONE;
            m_row_reg  <= '0;
            m_x_reg    <= '0;
            m_y_reg    <= '0;
            m_z_reg    <= '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {m_z_reg, m_y_reg, m_x_reg, m_row_reg};

    // checks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_solve_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_cmd == CMD_SOLVE) |=> !m_tvalid)
        else $error("result slot busy after solve accept");

    a_target_row: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EL_WR |-> t_idx != i_reg)
        else $error("elimination writes the source row");

endmodule
